@@ rtl/vlsc_pkg.sv @@
package vlsc_pkg;

   // Fixed widths of the character stream and the register port.
   localparam int CharW         = 8;
   localparam int CsrDataW      = 64;
   localparam int CsrIndexW     = 3;
   localparam int KeyLenW       = 5;
   localparam int ShiftW        = 5;
   localparam int KeyLettersMax = 16;
   localparam int BytesPerWord  = 8;

   // Register indexes.
   localparam logic [CsrIndexW-1:0] CsrMode        = 3'd0;
   localparam logic [CsrIndexW-1:0] CsrKeyLength   = 3'd1;
   localparam logic [CsrIndexW-1:0] CsrKeyLettersLo = 3'd2;
   localparam logic [CsrIndexW-1:0] CsrKeyLettersHi = 3'd3;

   // Mode codes.
   localparam logic ModeEncrypt = 1'b0;
   localparam logic ModeDecrypt = 1'b1;

   // ASCII landmarks.
   localparam logic [CharW-1:0] UpperA      = 8'd65;
   localparam logic [CharW-1:0] UpperZ      = 8'd90;
   localparam logic [CharW-1:0] LowerA      = 8'd97;
   localparam logic [CharW-1:0] LowerZ      = 8'd122;
   localparam logic [CharW-1:0] LowerAMinus1 = 8'd96;
   localparam logic [CharW-1:0] CaseOffset  = 8'd32;
   localparam logic [5:0]       Alphabet    = 6'd26;

   typedef struct packed {
      logic               mode;
      logic [KeyLenW-1:0] length;   // already saturated to the usable range
   } cfg_type;

   function automatic logic is_upper(input logic [CharW-1:0] c);
      return c inside {[UpperA:UpperZ]};
   endfunction

   function automatic logic is_lower(input logic [CharW-1:0] c);
      return c inside {[LowerA:LowerZ]};
   endfunction

   // Shift given by one key byte: a or A gives 1 through z or Z giving 26,
   // anything else gives no shift at all.
   function automatic logic [ShiftW-1:0] key_shift(input logic [CharW-1:0] b);
      logic [CharW-1:0] folded;
      logic [CharW-1:0] diff;
      folded = is_upper(b) ? (b + CaseOffset) : b;
      diff   = folded - LowerAMinus1;
      return is_lower(folded) ? diff[ShiftW-1:0] : '0;
   endfunction

endpackage

@@ rtl/vlsc_csr.sv @@
module vlsc_csr
   import vlsc_pkg::*;
#(
   parameter int MAX_KEY_LETTERS = KeyLettersMax
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [CsrIndexW-1:0]                  csr_index,
   input  logic [CsrDataW-1:0]                   csr_wdata,
   output cfg_type                               cfg,
   output logic [MAX_KEY_LETTERS-1:0][CharW-1:0] key_bytes
);

   localparam logic [KeyLenW-1:0] MaxLen = KeyLenW'(MAX_KEY_LETTERS);

   logic                                  mode_ff;
   logic [KeyLenW-1:0]                    length_ff;
   logic [KeyLenW-1:0]                    length_in;
   logic [MAX_KEY_LETTERS-1:0][CharW-1:0] key_bytes_ff;

   // The length is saturated on the way in, so the datapath sees 1..MAX only.
   always_comb begin
      if (csr_wdata[KeyLenW-1:0] == '0) begin
         length_in = KeyLenW'(1);
      end else if (csr_wdata[KeyLenW-1:0] > MaxLen) begin
         length_in = MaxLen;
      end else begin
         length_in = csr_wdata[KeyLenW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ModeEncrypt;
         length_ff    <= KeyLenW'(1);
         key_bytes_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CsrMode: begin
               mode_ff <= csr_wdata[0];
            end
            CsrKeyLength: begin
               length_ff <= length_in;
            end
            CsrKeyLettersLo: begin
               for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
                  if (i < BytesPerWord) begin
                     key_bytes_ff[i] <= csr_wdata[(i % BytesPerWord) * CharW +: CharW];
                  end
               end
            end
            CsrKeyLettersHi: begin
               for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
                  if (i >= BytesPerWord) begin
                     key_bytes_ff[i] <= csr_wdata[(i % BytesPerWord) * CharW +: CharW];
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.mode   = mode_ff;
   assign cfg.length = length_ff;
   assign key_bytes  = key_bytes_ff;

endmodule

@@ rtl/vlsc_datapath.sv @@
module vlsc_datapath
   import vlsc_pkg::*;
#(
   parameter int MAX_KEY_LETTERS = KeyLettersMax
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cfg_type                               cfg,
   input  logic [MAX_KEY_LETTERS-1:0][CharW-1:0] key_bytes,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [CharW-1:0]                      req_in_char,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [CharW-1:0]                      rsp_out_char
);

   localparam int PosW = (MAX_KEY_LETTERS > 1) ? $clog2(MAX_KEY_LETTERS) : 1;

   logic             s1_valid_ff, s1_valid_in;
   logic [CharW-1:0] s1_char_ff, s1_char_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CharW-1:0] rsp_char_ff, rsp_char_in;
   logic [PosW-1:0]  pos_ff, pos_in;

   logic               advance;
   logic               upper;
   logic               letter;
   logic [CharW-1:0]   base;
   logic [CharW-1:0]   rel;
   logic [PosW-1:0]    pos_use;
   logic [ShiftW-1:0]  shift;
   logic [5:0]         sum;
   logic [5:0]         wrapped;
   logic [KeyLenW-1:0] pos_next;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      upper  = is_upper(s1_char_ff);
      letter = upper || is_lower(s1_char_ff);
      base   = upper ? UpperA : LowerA;
      rel    = s1_char_ff - base;

      // A position left beyond a shortened key restarts at the first letter.
      pos_use = (KeyLenW'(pos_ff) >= cfg.length) ? '0 : pos_ff;
      shift   = key_shift(key_bytes[pos_use]);

      if (cfg.mode == ModeDecrypt) begin
         sum = {1'b0, rel[ShiftW-1:0]} + Alphabet - {1'b0, shift};
      end else begin
         sum = {1'b0, rel[ShiftW-1:0]} + {1'b0, shift};
      end
      wrapped  = (sum >= Alphabet) ? (sum - Alphabet) : sum;
      pos_next = KeyLenW'(pos_use) + KeyLenW'(1);

      s1_valid_in  = s1_valid_ff;
      s1_char_in   = s1_char_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      pos_in       = pos_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         if (letter) begin
            rsp_char_in = base + CharW'(wrapped);
            pos_in      = (pos_next >= cfg.length) ? '0 : pos_next[PosW-1:0];
         end else begin
            rsp_char_in = s1_char_ff;
         end
      end
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_char_in  = req_in_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_char_ff  <= s1_char_in;
      rsp_char_ff <= rsp_char_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_char = rsp_char_ff;

   // A character that is not a letter passes through and leaves the key alone.
   a_nonletter_passes: assert property (@(posedge clock) disable iff (reset)
      advance && !letter |=> rsp_char_ff == $past(s1_char_ff) && $stable(pos_ff))
      else $error("non-letter item altered or key position moved");

   // Letters keep their case.
   a_upper_kept: assert property (@(posedge clock) disable iff (reset)
      advance && upper |=> is_upper(rsp_char_ff))
      else $error("upper-case letter left its case");

   a_lower_kept: assert property (@(posedge clock) disable iff (reset)
      advance && letter && !upper |=> is_lower(rsp_char_ff))
      else $error("lower-case letter left its case");

   // With both stages full and the receiver stalled, no item may be taken.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_ready |-> !req_ready)
      else $error("item accepted while both stages are full");

endmodule

@@ rtl/vigenere_letter_shift_cipher_core.sv @@
// Letter shift cipher core, one character per item.
//
// Characters arrive on the req_ channel (req_valid, req_ready, req_in_char)
// and leave on the rsp_ channel (rsp_valid, rsp_ready, rsp_out_char), one
// result item for every input item and in the same order. An ASCII letter is
// shifted by the current key letter (a is 1 through z is 26), forward when
// mode is 0 and back when mode is 1, wrapping within its own case; the key
// position then moves on cyclically. Every other byte passes unchanged. The
// key, length and mode are written through the csr_ port, one register per
// cycle; the user must do so only while no item is in flight (unenforced).
//
// Each accepted item is held in one input register and then in one result
// register, with the letter test, key select, add and wrap between them; it
// moves on into the result register when that is empty or being emptied.
// Throughput is one item per cycle while the receiver keeps taking results.
// When the receiver stalls, the result register holds and the input register
// takes one more item before req_ready falls.
// Reset clears both stages, returns the key position to the first letter and
// sets mode to encrypt, key length to one and all key bytes to zero.
module vigenere_letter_shift_cipher_core
   import vlsc_pkg::*;
#(
   parameter int MAX_KEY_LETTERS = KeyLettersMax
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CharW-1:0]     req_in_char,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CharW-1:0]     rsp_out_char,
   input  logic                 csr_wr_en,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   cfg_type                               cfg;
   logic [MAX_KEY_LETTERS-1:0][CharW-1:0] key_bytes;

   // Configuration registers; the key length is saturated when written.
   vlsc_csr #(
      .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .key_bytes (key_bytes)
   );

   // Two-stage character path with the key position register.
   vlsc_datapath #(
      .MAX_KEY_LETTERS(MAX_KEY_LETTERS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .key_bytes    (key_bytes),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_char  (req_in_char),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char)
   );

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for the letter shift cipher core.
module testbench;
   import vlsc_pkg::*;

   localparam int HalfPeriod    = 4;
   localparam int ResetCycles   = 6;
   localparam int WatchdogLimit = 2000;
   localparam int RandomPhases  = 20;
   localparam int CharsPerPhase = 85;
   localparam int IdlePercent   = 22;
   localparam int DrainCycles   = 3;

   // Every input of the block starts at a known value.
   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   logic [CharW-1:0]     req_in_char  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   logic [CharW-1:0]     rsp_out_char;
   logic                 csr_wr_en    = 1'b0;
   logic [CsrIndexW-1:0] csr_index    = '0;
   logic [CsrDataW-1:0]  csr_wdata    = '0;

   // Our own copy of the registers and of the key position.
   logic                 cfg_mode;
   logic [KeyLenW-1:0]   cfg_len;
   logic [CsrDataW-1:0]  key_lo;
   logic [CsrDataW-1:0]  key_hi;
   logic [3:0]           key_pos;

   // Characters waiting to be offered, and the cipher output still owed by the block.
   logic [CharW-1:0]     chars_to_send[$];
   logic [CharW-1:0]     ciphered_due[$];

   bit idle_on       = 1'b1;
   int errors        = 0;
   int chars_checked = 0;
   int settings      = 1;
   int quiet_cycles  = 0;

   vigenere_letter_shift_cipher_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_char  (req_in_char),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // Works out the cipher output for one character and moves the key position on,
   // exactly as the block should. Non-letters come straight back and leave the
   // position alone.
   function automatic logic [CharW-1:0] shift_char(input logic [CharW-1:0] c);
      int len;
      int pos;
      int base;
      int shift;
      int off;
      logic [CharW-1:0]    kb;
      logic [CsrDataW-1:0] word;
      if (c >= UpperA && c <= UpperZ) base = int'(UpperA);
      else if (c >= LowerA && c <= LowerZ) base = int'(LowerA);
      else return c;
      // A length of zero behaves as one, and anything above the key store saturates.
      len = (cfg_len == 0) ? 1 : (cfg_len > KeyLettersMax) ? KeyLettersMax : int'(cfg_len);
      // A position left beyond a shortened key falls back to the first letter.
      pos  = (int'(key_pos) >= len) ? 0 : int'(key_pos);
      word = (pos >= BytesPerWord) ? key_hi : key_lo;
      kb   = word[(pos % BytesPerWord) * 8 +: 8];
      if (kb >= UpperA && kb <= UpperZ) kb = kb + CaseOffset;
      // A key byte that is not a letter gives no shift at all.
      shift = (kb >= LowerA && kb <= LowerZ) ? int'(kb) - int'(LowerAMinus1) : 0;
      off   = int'(c) - base;
      if (cfg_mode == ModeDecrypt) off = off + int'(Alphabet) - shift;
      else off = off + shift;
      if (off >= int'(Alphabet)) off = off - int'(Alphabet);
      key_pos = (pos + 1 >= len) ? 4'd0 : 4'(pos + 1);
      return CharW'(base + off);
   endfunction

   function automatic logic [CharW-1:0] random_letter();
      return ($urandom_range(1) ? UpperA : LowerA) + CharW'($urandom_range(25));
   endfunction

   // Key bytes are mostly letters, with the odd stray byte that must give no shift.
   function automatic logic [CsrDataW-1:0] random_key_word();
      logic [CsrDataW-1:0] w;
      for (int i = 0; i < BytesPerWord; i++) begin
         w[i*8 +: 8] = ($urandom_range(99) < 85) ? random_letter() : CharW'($urandom_range(255));
      end
      return w;
   endfunction

   // One register write, mirrored into our copy at the same moment. Only called
   // while nothing is in flight, so no character can see a half-written setting.
   task automatic write_reg(input logic [CsrIndexW-1:0] idx, input logic [CsrDataW-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CsrMode:         cfg_mode = data[0];
         CsrKeyLength:    cfg_len  = data[KeyLenW-1:0];
         CsrKeyLettersLo: key_lo   = data;
         CsrKeyLettersHi: key_hi   = data;
         default: ;  // The block ignores indexes past the register list.
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) chars_to_send.push_back(s[i]);
   endtask

   // Holds the sender back until every owed result has come home, then lets the
   // two-stage pipeline settle before returning. Sampling on the falling edge
   // keeps clear of the driver and the monitor.
   task automatic wait_drained();
      do @(negedge clock); while (chars_to_send.size() != 0 || ciphered_due.size() != 0);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Driver. An item is offered when the previous one has gone (or none was
   // up), and its cipher output is worked out as it is offered: items are
   // accepted in the order offered and settings never change with one in flight.
   always @(posedge clock) begin : drive_chars
      logic [CharW-1:0] ch;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (chars_to_send.size() != 0 && !(idle_on && $urandom_range(99) < IdlePercent)) begin
            ch = chars_to_send.pop_front();
            ciphered_due.push_back(shift_char(ch));
            req_valid   <= 1'b1;
            req_in_char <= ch;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor. Each result item is checked against the oldest cipher output owed.
   always @(posedge clock) begin : check_chars
      logic [CharW-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            chars_checked++;
            if (ciphered_due.size() == 0) begin
               $error("out_char: no result item owed, got %02h", rsp_out_char);
               errors++;
            end else begin
               want = ciphered_due.pop_front();
               if (rsp_out_char !== want) begin
                  $error("out_char: expected %02h, actual %02h", want, rsp_out_char);
                  errors++;
               end
            end
         end
         rsp_ready <= !(idle_on && $urandom_range(99) < IdlePercent);
      end
   end

   // Watchdog: a long run of cycles with no handshake and no register write
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("Timed out after %0d cycles without progress.", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int len_sel;
      cfg_mode = ModeEncrypt;
      cfg_len  = KeyLenW'(1);
      key_lo   = '0;
      key_hi   = '0;
      key_pos  = '0;
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset every key byte is zero, which is not a letter:
      // letters pass unchanged. Both ends of each case, the neighbours of each
      // letter range and bytes from the top half go through.
      queue_text("AZaz@[`{0");
      chars_to_send.push_back(8'h00);
      chars_to_send.push_back(8'h7F);
      chars_to_send.push_back(8'h80);
      chars_to_send.push_back(8'hFF);
      wait_drained();

      // Decrypt with a length beyond the key store, so it saturates to the full
      // sixteen. The key mixes both cases, a and z, and several stray bytes.
      // Low word: a Z ! m z A q `   High word: b Y 0 t { W @ k
      write_reg(CsrMode, CsrDataW'(ModeDecrypt));
      write_reg(CsrKeyLength, CsrDataW'(31));
      write_reg(CsrKeyLettersLo, 64'h6071_417A_6D21_5A61);
      write_reg(CsrKeyLettersHi, 64'h6B40_577B_7430_5962);
      settings++;
      queue_text("Az.aZmByqx");
      wait_drained();

      // A length of zero counts as one. The key position is now well past it,
      // so the next letter must fall back to key letter zero.
      write_reg(CsrMode, CsrDataW'(ModeEncrypt));
      write_reg(CsrKeyLength, CsrDataW'(0));
      settings++;
      queue_text("Za");
      wait_drained();

      // Random part. Every phase starts from an empty pipeline, so the sender
      // is regularly held back until all owed results have arrived. The key
      // position carries over, which exercises a shortened key length.
      for (int p = 0; p < RandomPhases; p++) begin
         // One stretch of phases runs with both sides at full speed.
         idle_on = !(p >= 6 && p <= 9);
         if (p == 0 || $urandom_range(99) < 60) begin
            write_reg(CsrMode, CsrDataW'($urandom_range(1)));
         end
         if (p < 2 || $urandom_range(99) < 60) begin
            len_sel = $urandom_range(9);
            if (p == 0) write_reg(CsrKeyLength, CsrDataW'(KeyLettersMax));
            else if (p == 1) write_reg(CsrKeyLength, CsrDataW'(1));
            else if (len_sel == 0) write_reg(CsrKeyLength, CsrDataW'(0));
            else if (len_sel == 1) write_reg(CsrKeyLength, CsrDataW'($urandom_range(17, 31)));
            else write_reg(CsrKeyLength, CsrDataW'($urandom_range(1, KeyLettersMax)));
         end
         if (p == 0 || $urandom_range(99) < 60) write_reg(CsrKeyLettersLo, random_key_word());
         if (p == 0 || $urandom_range(99) < 60) write_reg(CsrKeyLettersHi, random_key_word());
         if ($urandom_range(99) < 25) begin
            write_reg(CsrIndexW'($urandom_range(CsrKeyLettersHi + 1, (1 << CsrIndexW) - 1)),
                      {$urandom, $urandom});
         end
         settings++;
         for (int i = 0; i < CharsPerPhase; i++) begin
            if ($urandom_range(99) < 75) chars_to_send.push_back(random_letter());
            else chars_to_send.push_back(CharW'($urandom_range(255)));
         end
         wait_drained();
      end

      $display("%0d characters checked across %0d register settings, both directions.",
               chars_checked, settings);
      $display("Both channels were stalled at random, with one stretch running flat out.");
      if (errors == 0 && ciphered_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
